// ===== hw/rtl/gdbw_pkg.sv =====
// ----------------------------------------------------------------------------
// gdbw_pkg: graph walker shared types
// Item codes, command word, engine states and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package gdbw_pkg;

  localparam int VTX_W     = 6;
  localparam int ACT_W     = 2;
  localparam int MAX_NODES = 64;

  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DFS = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BFS = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DFS,
    OP_BFS
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WA,
    S_ADD_WB,
    S_D_RD,
    S_D_EVAL,
    S_D_POP,
    S_D_TOP,
    S_B_DEQ,
    S_B_DQ2,
    S_B_SCAN,
    S_B_ENQ,
    S_FLUSH
  } eng_state_t;

  function automatic logic [VTX_W-1:0] lowest_bit(input logic [MAX_NODES-1:0] x);
    logic [VTX_W-1:0] r;
    r = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (x[i]) r = VTX_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gdbw_if.sv =====
// ----------------------------------------------------------------------------
// gdbw_if: graph walker channels
// Item channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface gdbw_in_if;
  logic                            valid;
  logic                            ready;
  logic [gdbw_pkg::ACT_W-1:0]      action;
  logic [gdbw_pkg::VTX_W-1:0]      vertex_a;
  logic [gdbw_pkg::VTX_W-1:0]      vertex_b;

  modport source (output valid, action, vertex_a, vertex_b, input ready);
  modport sink   (input valid, action, vertex_a, vertex_b, output ready);
endinterface

interface gdbw_out_if;
  logic                            valid;
  logic                            ready;
  logic [gdbw_pkg::VTX_W-1:0]      visited_vertex;
  logic                            last_of_walk;

  modport source (output valid, visited_vertex, last_of_walk, input ready);
  modport sink   (input valid, visited_vertex, last_of_walk, output ready);
endinterface

// ===== hw/rtl/gdbw_front.sv =====
// ----------------------------------------------------------------------------
// gdbw_front: item intake
// Accepts item words, drops unusable ones and queues commands for the engine.
// ----------------------------------------------------------------------------
module gdbw_front #(
  parameter int NODES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  gdbw_in_if.sink        in_ch,
  output gdbw_pkg::cmd_t cmd,
  output logic           cmd_vld,
  input  logic           cmd_rdy
);
  import gdbw_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       a_ok;
  logic       b_ok;
  logic       keep;
  cmd_t       c_in;
  logic       push;
  logic       pop;

  always_comb begin
    a_ok    = {1'b0, in_ch.vertex_a} < (VTX_W + 1)'(NODES);
    b_ok    = {1'b0, in_ch.vertex_b} < (VTX_W + 1)'(NODES);
    c_in.va = in_ch.vertex_a;
    c_in.vb = in_ch.vertex_b;
    case (in_ch.action)
      ACT_ADD: begin
        keep    = a_ok && b_ok;
        c_in.op = OP_ADD;
      end
      ACT_DFS: begin
        keep    = a_ok;
        c_in.op = OP_DFS;
      end
      ACT_BFS: begin
        keep    = a_ok;
        c_in.op = OP_BFS;
      end
      default: begin
        keep    = 1'b0;
        c_in.op = OP_ADD;
      end
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign cmd_vld     = (cnt_r != 2'd0);
  assign cmd         = q_r[rp_r];
  assign pop         = cmd_vld && cmd_rdy;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/gdbw_engine.sv =====
// ----------------------------------------------------------------------------
// gdbw_engine: walk sequencer
// Holds the adjacency matrix, stack and queue; runs edge adds and walks.
// ----------------------------------------------------------------------------
module gdbw_engine #(
  parameter int NODES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gdbw_pkg::cmd_t cmd,
  input  logic           cmd_vld,
  output logic           cmd_rdy,
  gdbw_out_if.source     out_ch
);
  import gdbw_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam int PW = $clog2(NODES + 1);

  eng_state_t       st_r, st_nxt;

  logic [NODES-1:0] adj_mem [NODES];
  logic [NODES-1:0] row_vld_r;
  logic [NODES-1:0] adj_q;
  logic             adj_q_vld_r;
  logic [IW-1:0]    adj_ra;
  logic [IW-1:0]    adj_wa;
  logic [NODES-1:0] adj_wd;
  logic             adj_we;

  logic [IW-1:0]    stk_mem [NODES];
  logic [IW-1:0]    stk_q;
  logic [IW-1:0]    stk_addr;
  logic [IW-1:0]    stk_wd;
  logic             stk_we;
  logic             stk_re;

  logic [IW-1:0]    que_mem [NODES];
  logic [IW-1:0]    que_q;
  logic [IW-1:0]    que_addr;
  logic [IW-1:0]    que_wd;
  logic             que_we;
  logic             que_re;

  logic [NODES-1:0] vis_r, vis_nxt;
  logic [NODES-1:0] cand_r, cand_nxt;
  logic [PW-1:0]    sp_r, sp_nxt;
  logic [PW-1:0]    hd_r, hd_nxt;
  logic [PW-1:0]    tl_r, tl_nxt;
  logic [PW-1:0]    sp_dec;
  logic [IW-1:0]    top_r, top_nxt;
  logic [IW-1:0]    va_r, va_nxt;
  logic [IW-1:0]    vb_r, vb_nxt;
  logic [IW-1:0]    pend_r, pend_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [VTX_W-1:0] out_v_r, out_v_nxt;
  logic             out_last_r, out_last_nxt;

  logic [NODES-1:0] row;
  logic [NODES-1:0] cand_now;
  logic [NODES-1:0] enc_in;
  logic [VTX_W-1:0] low_full;
  logic [IW-1:0]    low;
  logic [IW-1:0]    ca;
  logic             can_emit;

  assign row      = adj_q_vld_r ? adj_q : '0;
  assign cand_now = row & ~vis_r;
  assign enc_in   = (st_r == S_B_ENQ) ? cand_r : cand_now;
  assign low_full = lowest_bit(MAX_NODES'(enc_in));
  assign low      = low_full[IW-1:0];
  assign ca       = cmd.va[IW-1:0];
  assign sp_dec   = sp_r - PW'(1);
  assign can_emit = !out_vld_r || out_ch.ready;

  assign out_ch.valid          = out_vld_r;
  assign out_ch.visited_vertex = out_v_r;
  assign out_ch.last_of_walk   = out_last_r;

  always_comb begin
    st_nxt       = st_r;
    vis_nxt      = vis_r;
    cand_nxt     = cand_r;
    sp_nxt       = sp_r;
    hd_nxt       = hd_r;
    tl_nxt       = tl_r;
    top_nxt      = top_r;
    va_nxt       = va_r;
    vb_nxt       = vb_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_v_nxt    = out_v_r;
    out_last_nxt = out_last_r;
    cmd_rdy      = 1'b0;
    adj_ra       = top_r;
    adj_we       = 1'b0;
    adj_wa       = va_r;
    adj_wd       = row | (NODES'(1) << vb_r);
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_addr     = sp_r[IW-1:0];
    stk_wd       = low;
    que_we       = 1'b0;
    que_re       = 1'b0;
    que_addr     = tl_r[IW-1:0];
    que_wd       = low;
    case (st_r)
      S_IDLE: begin
        cmd_rdy = 1'b1;
        adj_ra  = ca;
        if (cmd_vld) begin
          va_nxt = ca;
          vb_nxt = cmd.vb[IW-1:0];
          case (cmd.op)
            OP_ADD: st_nxt = S_ADD_WA;
            OP_DFS: begin
              vis_nxt      = NODES'(1) << ca;
              stk_we       = 1'b1;
              stk_addr     = '0;
              stk_wd       = ca;
              sp_nxt       = PW'(1);
              top_nxt      = ca;
              pend_nxt     = ca;
              pend_vld_nxt = 1'b1;
              st_nxt       = S_D_RD;
            end
            OP_BFS: begin
              vis_nxt      = NODES'(1) << ca;
              que_we       = 1'b1;
              que_addr     = '0;
              que_wd       = ca;
              hd_nxt       = '0;
              tl_nxt       = PW'(1);
              pend_vld_nxt = 1'b0;
              st_nxt       = S_B_DEQ;
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_WA: begin
        adj_we = 1'b1;
        adj_wa = va_r;
        adj_wd = row | (NODES'(1) << vb_r);
        adj_ra = vb_r;
        st_nxt = S_ADD_WB;
      end
      S_ADD_WB: begin
        adj_we = 1'b1;
        adj_wa = vb_r;
        adj_wd = row | (NODES'(1) << va_r);
        st_nxt = S_IDLE;
      end
      S_D_RD: begin
        st_nxt = S_D_EVAL;
      end
      S_D_EVAL: begin
        if (cand_now != '0) begin
          if (can_emit) begin
            out_vld_nxt  = 1'b1;
            out_v_nxt    = VTX_W'(pend_r);
            out_last_nxt = 1'b0;
            pend_nxt     = low;
            vis_nxt      = vis_r | (NODES'(1) << low);
            stk_we       = 1'b1;
            stk_addr     = sp_r[IW-1:0];
            stk_wd       = low;
            sp_nxt       = sp_r + PW'(1);
            top_nxt      = low;
            st_nxt       = S_D_RD;
          end
        end else begin
          sp_nxt = sp_dec;
          st_nxt = (sp_r == PW'(1)) ? S_FLUSH : S_D_POP;
        end
      end
      S_D_POP: begin
        stk_re   = 1'b1;
        stk_addr = sp_dec[IW-1:0];
        st_nxt   = S_D_TOP;
      end
      S_D_TOP: begin
        top_nxt = stk_q;
        adj_ra  = stk_q;
        st_nxt  = S_D_EVAL;
      end
      S_B_DEQ: begin
        if (hd_r != tl_r) begin
          que_re   = 1'b1;
          que_addr = hd_r[IW-1:0];
          hd_nxt   = hd_r + PW'(1);
          st_nxt   = S_B_DQ2;
        end else begin
          st_nxt = S_FLUSH;
        end
      end
      S_B_DQ2: begin
        adj_ra = que_q;
        if (!pend_vld_r || can_emit) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_v_nxt    = VTX_W'(pend_r);
            out_last_nxt = 1'b0;
          end
          pend_nxt     = que_q;
          pend_vld_nxt = 1'b1;
          st_nxt       = S_B_SCAN;
        end
      end
      S_B_SCAN: begin
        cand_nxt = cand_now;
        st_nxt   = S_B_ENQ;
      end
      S_B_ENQ: begin
        if (cand_r != '0) begin
          cand_nxt = cand_r & ~(NODES'(1) << low);
          vis_nxt  = vis_r | (NODES'(1) << low);
          que_we   = 1'b1;
          que_addr = tl_r[IW-1:0];
          que_wd   = low;
          tl_nxt   = tl_r + PW'(1);
        end else begin
          st_nxt = S_B_DEQ;
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          out_vld_nxt  = 1'b1;
          out_v_nxt    = VTX_W'(pend_r);
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_q <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_addr] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (que_we) que_mem[que_addr] <= que_wd;
    if (que_re) que_q <= que_mem[que_addr];
  end

  always_ff @(posedge clk) begin
    vis_r    <= vis_nxt;
    cand_r   <= cand_nxt;
    top_r    <= top_nxt;
    va_r     <= va_nxt;
    vb_r     <= vb_nxt;
    pend_r   <= pend_nxt;
    out_v_r  <= out_v_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      row_vld_r   <= '0;
      adj_q_vld_r <= 1'b0;
      sp_r        <= '0;
      hd_r        <= '0;
      tl_r        <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      if (adj_we) row_vld_r[adj_wa] <= 1'b1;
      adj_q_vld_r <= row_vld_r[adj_ra];
      sp_r        <= sp_nxt;
      hd_r        <= hd_nxt;
      tl_r        <= tl_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(NODES))
    else $error("stack pointer beyond vertex count");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending vertex left after walk");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    hd_r <= tl_r)
    else $error("queue head passed tail");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FLUSH && can_emit) |=> (st_r == S_IDLE && out_vld_r && out_last_r))
    else $error("walk end not marked last");
`endif

endmodule

// ===== hw/rtl/graph_dfs_bfs_walker.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_bfs_walker: depth-first and breadth-first graph walker
// Edge add: states S_ADD_WA then S_ADD_WB write both rows; no result word.
// Depth-first: S_D_RD, S_D_EVAL per visit; S_D_POP, S_D_TOP per backtrack.
// Breadth-first: S_B_DEQ, S_B_DQ2, S_B_SCAN per dequeue; S_B_ENQ per enqueue.
// Reset clears all edges at once through per-row valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_walker #(
  parameter int NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  gdbw_in_if.sink     in_ch,
  gdbw_out_if.source  out_ch
);
  import gdbw_pkg::*;

  cmd_t cmd;
  logic cmd_vld;
  logic cmd_rdy;

  gdbw_front #(.NODES(NODES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cmd     (cmd),
    .cmd_vld (cmd_vld),
    .cmd_rdy (cmd_rdy)
  );

  gdbw_engine #(.NODES(NODES)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .cmd_vld (cmd_vld),
    .cmd_rdy (cmd_rdy),
    .out_ch  (out_ch)
  );

endmodule

// ===== verif/tb_graph_dfs_bfs_walker.sv =====
// ----------------------------------------------------------------------------
// tb_graph_dfs_bfs_walker: graph walker self-checking bench
// Builds graphs with edge words, runs depth-first and breadth-first walks and
// checks every visited-vertex word against an in-bench walk predictor.
// ----------------------------------------------------------------------------
module tb_graph_dfs_bfs_walker;
  import gdbw_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
  } item_t;

  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic             last;
  } visit_t;

  typedef struct {
    item_t  it;
    logic   has_exp;
    visit_t exp;
  } row_t;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  gdbw_in_if  in_ch();
  gdbw_out_if out_ch();

  graph_dfs_bfs_walker #(.NODES(64)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [63:0] adj_rows [64];
  visit_t      pending_visits [$];
  visit_t      typed_visits [$];
  int          errors = 0;
  int          walks = 0;
  int          words_seen = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;

  function automatic int low_idx(logic [63:0] x);
    for (int i = 0; i < 64; i++) if (x[i]) return i;
    return 63;
  endfunction

  function automatic void predict_walk(item_t it);
    logic [63:0] seen;
    logic [5:0]  stk [64];
    logic [5:0]  q [64];
    int sp, hd, tl, n, u, nx;
    logic [63:0] cand;
    visit_t v;
    n = 0;
    if (it.action == ACT_ADD) begin
      adj_rows[it.va][it.vb] = 1'b1;
      adj_rows[it.vb][it.va] = 1'b1;
      return;
    end
    if (it.action == ACT_NONE) return;
    walks++;
    seen = 64'd1 << it.va;
    if (it.action == ACT_DFS) begin
      sp = 1;
      stk[0] = it.va;
      v.vtx = it.va; v.last = 1'b0;
      pending_visits.insert(pending_visits.size(), v); n++;
      while (sp > 0) begin
        cand = adj_rows[stk[sp-1]] & ~seen;
        if (cand != 0 && n < 64 && sp < 64) begin
          nx = low_idx(cand);
          seen[nx] = 1'b1;
          stk[sp] = 6'(nx); sp++;
          v.vtx = 6'(nx);
          pending_visits.insert(pending_visits.size(), v); n++;
        end else begin
          sp--;
        end
      end
    end else begin
      hd = 0; tl = 1;
      q[0] = it.va;
      while (hd < tl && hd < 64) begin
        u = int'(q[hd]); hd++;
        if (n < 64) begin
          v.vtx = 6'(u); v.last = 1'b0;
          pending_visits.insert(pending_visits.size(), v); n++;
        end
        cand = adj_rows[u] & ~seen;
        while (cand != 0 && tl < 64) begin
          nx = low_idx(cand);
          cand[nx] = 1'b0;
          seen[nx] = 1'b1;
          q[tl] = 6'(nx); tl++;
        end
      end
    end
    pending_visits[pending_visits.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_graph_dfs_bfs_walker: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    visit_t got, want, tv;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.vtx = out_ch.visited_vertex;
      got.last = out_ch.last_of_walk;
      words_seen++;
      if (pending_visits.size() == 0) begin
        errors++;
        $display("%0t: unexpected word vertex=%0d last=%0b", $time, got.vtx, got.last);
      end else begin
        want = pending_visits.pop_front();
        if (typed_visits.size() > 0) begin
          tv = typed_visits.pop_front();
          if (got !== tv) begin
            errors++;
            $display("%0t: directed word expected %0d/%0b actual %0d/%0b",
                     $time, tv.vtx, tv.last, got.vtx, got.last);
          end
        end
        if (got.vtx !== want.vtx) begin
          errors++;
          $display("%0t: vertex expected %0d actual %0d", $time, want.vtx, got.vtx);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_word(item_t it);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= it.action;
    in_ch.vertex_a <= it.va;
    in_ch.vertex_b <= it.vb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_walk(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_visits.size() != 0) @(negedge clk);
  endtask

  row_t directed [15] = '{
    '{'{ACT_DFS, 6'd0, 6'd0}, 1'b1, '{6'd0, 1'b1}},
    '{'{ACT_BFS, 6'd63, 6'd0}, 1'b1, '{6'd63, 1'b1}},
    '{'{ACT_NONE, 6'd5, 6'd9}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_ADD, 6'd7, 6'd7}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_DFS, 6'd7, 6'd0}, 1'b1, '{6'd7, 1'b1}},
    '{'{ACT_ADD, 6'd0, 6'd63}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_ADD, 6'd63, 6'd0}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_ADD, 6'd0, 6'd1}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_ADD, 6'd1, 6'd2}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_ADD, 6'd0, 6'd3}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_ADD, 6'd42, 6'd21}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_DFS, 6'd0, 6'd63}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_BFS, 6'd0, 6'd42}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_BFS, 6'd21, 6'd63}, 1'b0, '{6'd0, 1'b0}},
    '{'{ACT_DFS, 6'd63, 6'd21}, 1'b0, '{6'd0, 1'b0}}
  };

  initial begin
    item_t it;
    int r;
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].has_exp)
        typed_visits.insert(typed_visits.size(), directed[i].exp);
      send_word(directed[i].it);
    end
    wait_drained();

    // random part: clustered edges, a ring over all vertices and walks, interleaved
    for (int k = 0; k < 24; k++) begin
      if (k == 8) wait_drained();
      if (k == 10) begin
        wait_drained();
        repeat (10) @(negedge clk);
        for (int i = 0; i < 64; i++) begin
          it.action = ACT_ADD;
          it.va = VTX_W'(i);
          it.vb = VTX_W'((i + 1) % 64);
          send_word(it);
        end
      end
      if (k == 18) no_idle = 1'b1;
      r = $urandom_range(0, 9);
      if (r < 5) begin
        it.action = ACT_ADD;
        it.va = VTX_W'($urandom_range(0, 15));
        it.vb = ($urandom_range(0, 3) == 0) ? VTX_W'($urandom_range(0, 63))
                                            : VTX_W'($urandom_range(0, 15));
      end else if (r == 9) begin
        it.action = ACT_W'($urandom_range(0, 3));
        it.va = VTX_W'($urandom_range(0, 63));
        it.vb = VTX_W'($urandom_range(0, 63));
      end else begin
        it.action = (r < 7) ? ACT_DFS : ACT_BFS;
        it.va = ($urandom_range(0, 3) == 0) ? VTX_W'($urandom_range(0, 63))
                                            : VTX_W'($urandom_range(0, 15));
        it.vb = VTX_W'($urandom_range(0, 63));
      end
      send_word(it);
    end

    wait_drained();
    repeat (200) @(negedge clk);
    $display("Ran %0d walks over growing graphs, %0d visited-vertex words checked.",
             walks, words_seen);
    if (errors == 0 && pending_visits.size() == 0) begin
      $display("tb_graph_dfs_bfs_walker: PASS");
    end else begin
      $display("tb_graph_dfs_bfs_walker: FAIL");
    end
    $finish;
  end

endmodule
